>>> design/pwts_pkg.sv
// Package for the priority wake-up task scheduler.
// Types, codes and constants shared by the front, queue and back modules.
package pwts_pkg;

  localparam int unsigned TaskSlots = 16;
  localparam int unsigned SlotW     = $clog2(TaskSlots);
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QIdxW     = $clog2(QDepth);
  localparam logic [19:0] TicksPerMsReset = 20'd10000;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_SLEEP = 2'd2,
    KIND_EXIT  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    MODE_FREE     = 2'd0,
    MODE_SLEEPING = 2'd1,
    MODE_READY    = 2'd2,
    MODE_RUNNING  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_REJECT = 2'd1,
    ST_NONE   = 2'd2
  } status_e;

  // Item as it travels from the front through the queue.
  typedef struct packed {
    kind_e       kind;
    logic [3:0]  slot;
    logic [2:0]  prio;
    logic [63:0] now;
    logic [63:0] wake; // now + ms * ticks_per_ms, saturated
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_WAKE,
    S_TICK_PICK0,
    S_TICK_SWITCH,
    S_SLEEP,
    S_EXIT_UNLINK,
    S_EXIT_SCAN,
    S_OUT
  } bstate_e;

endpackage

>>> design/pwts_front.sv
// Front end: accepts items, forms the saturated wake time: multiply, add.
// Depends on pwts_pkg.
module pwts_front import pwts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [3:0]  slot_i,
  input  logic [2:0]  prio_i,
  input  logic [63:0] now_ticks_i,
  input  logic [31:0] sleep_ms_i,
  input  logic [19:0] ticks_per_ms_i,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output cmd_t        cmd_o
);

  logic        busy_q, busy_d;
  logic        mul_q, mul_d;
  cmd_t        cmd_q, cmd_d;
  logic [31:0] ms_q, ms_d;
  logic [51:0] prod_q, prod_d;
  logic [64:0] sum;
  // Set once the add after the multiply has formed the wake time.
  logic        prod_valid_q, prod_valid_d;

  assign in_ready_o  = !busy_q;
  assign cmd_valid_o = busy_q && !mul_q && prod_valid_q;
  assign cmd_o       = cmd_q;
  assign sum         = {1'b0, cmd_q.now} + {13'd0, prod_q};

  always_comb begin
    busy_d = busy_q;
    mul_d  = mul_q;
    cmd_d  = cmd_q;
    ms_d   = ms_q;
    prod_d = prod_q;
    if (in_valid_i && in_ready_o) begin
      busy_d     = 1'b1;
      mul_d      = 1'b1;
      cmd_d.kind = kind_e'(kind_i);
      cmd_d.slot = slot_i;
      cmd_d.prio = prio_i;
      cmd_d.now  = now_ticks_i;
      ms_d       = sleep_ms_i;
    end else if (mul_q) begin
      // Tick uses one millisecond.
      prod_d = (cmd_q.kind == KIND_TICK) ? {32'd0, ticks_per_ms_i}
                                         : ms_q * ticks_per_ms_i;
      mul_d  = 1'b0;
      busy_d = 1'b1;
    end else if (cmd_valid_o && cmd_ready_i) begin
      busy_d = 1'b0;
    end
    if (busy_q && !mul_q && !prod_valid_q) begin
      cmd_d.wake = sum[64] ? '1 : sum[63:0];
    end
  end

  always_comb begin
    prod_valid_d = prod_valid_q;
    if (in_valid_i && in_ready_o) prod_valid_d = 1'b0;
    else if (busy_q && !mul_q) prod_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      mul_q        <= 1'b0;
      prod_valid_q <= 1'b0;
    end else begin
      busy_q       <= busy_d;
      mul_q        <= mul_d;
      prod_valid_q <= prod_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    ms_q   <= ms_d;
    prod_q <= prod_d;
  end

endmodule

>>> design/pwts_queue.sv
// Short queue between front end and back end.
// Depends on pwts_pkg.
module pwts_queue import pwts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  cmd_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output cmd_t rd_data_o
);

  cmd_t             mem_q [QDepth];
  logic [QIdxW-1:0] wp_q, rp_q;
  logic [QIdxW:0]   cnt_q;
  logic             wr, rd;

  assign wr_ready_o = cnt_q != (QIdxW + 1)'(QDepth);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr         = wr_valid_i && wr_ready_o;
  assign rd         = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + {{QIdxW{1'b0}}, wr} - {{QIdxW{1'b0}}, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

endmodule

>>> design/pwts_back.sv
// Back end: ring state and the sequencer that walks it one slot per cycle.
// Depends on pwts_pkg.
module pwts_back import pwts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  run_slot_o,
  output logic        run_valid_o,
  output logic [63:0] start_ticks_o,
  output logic [1:0]  status_o
);

  logic [SlotW-1:0] nxt_q [TaskSlots];
  mode_e            mode_q [TaskSlots];
  logic [2:0]       prio_q [TaskSlots];
  logic [63:0]      wake_q [TaskSlots];
  logic [SlotW-1:0] head_q, cur_q, pend_q;
  logic             ne_q, curv_q, pendv_q;

  bstate_e          st_q;
  cmd_t             c_q;
  logic [SlotW-1:0] t_q, stop_q, cand_q, early_q, first_q, prev_q;
  logic             have_q, any_q;
  logic [63:0]      best_q;
  logic [4:0]       guard_q;
  logic [63:0]      o_start_q;
  status_e          o_status_q;

  // current task registers do not move while a result waits
  assign cmd_ready_o   = (st_q == S_IDLE);
  assign out_valid_o   = (st_q == S_OUT);
  assign run_slot_o    = 4'(cur_q);
  assign run_valid_o   = curv_q;
  assign start_ticks_o = o_start_q;
  assign status_o      = o_status_q;

  logic [SlotW-1:0] tn, sl;
  logic [63:0]      w_eff;
  assign tn    = nxt_q[t_q];
  assign sl    = c_q.slot[SlotW-1:0];
  assign w_eff = (wake_q[t_q] > c_q.now) ? wake_q[t_q] : c_q.now;

  task automatic finish(input status_e s, input logic [63:0] st);
    o_status_q <= s;
    o_start_q  <= st;
    st_q       <= S_OUT;
  endtask

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      head_q  <= '0;
      cur_q   <= '0;
      pend_q  <= '0;
      ne_q    <= 1'b0;
      curv_q  <= 1'b0;
      pendv_q <= 1'b0;
      for (int i = 0; i < TaskSlots; i++) mode_q[i] <= MODE_FREE;
    end else begin
      case (st_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            c_q  <= cmd_i;
            st_q <= S_MUL;
          end
        end
        S_MUL: begin
          guard_q <= '0;
          have_q  <= 1'b0;
          any_q   <= 1'b0;
          case (c_q.kind)
            KIND_ADD: begin
              if (mode_q[sl] != MODE_FREE) begin
                finish(ST_REJECT, c_q.now);
              end else begin
                if (!ne_q) begin
                  nxt_q[sl] <= sl;
                  head_q    <= sl;
                  ne_q      <= 1'b1;
                end else begin
                  nxt_q[sl]     <= nxt_q[head_q];
                  nxt_q[head_q] <= sl;
                end
                mode_q[sl] <= MODE_SLEEPING;
                prio_q[sl] <= c_q.prio;
                wake_q[sl] <= '0;
                finish(ST_DONE, c_q.now);
              end
            end
            KIND_TICK: begin
              if (!ne_q) begin
                finish(ST_REJECT, c_q.now);
              end else if (pendv_q && mode_q[pend_q] == MODE_READY) begin
                // pending task still ready: no due scan
                st_q <= S_TICK_PICK0;
              end else begin
                stop_q <= curv_q ? cur_q : head_q;
                t_q    <= curv_q ? nxt_q[cur_q] : head_q;
                st_q   <= S_WAKE;
              end
            end
            KIND_SLEEP: begin
              if (!curv_q) begin
                finish(ST_REJECT, c_q.now);
              end else begin
                mode_q[cur_q] <= MODE_SLEEPING;
                wake_q[cur_q] <= c_q.wake;
                early_q       <= cur_q;
                t_q           <= nxt_q[cur_q];
                st_q          <= S_SLEEP;
              end
            end
            default: begin
              if (!curv_q) begin
                finish(ST_REJECT, c_q.now);
              end else begin
                first_q <= nxt_q[cur_q];
                prev_q  <= head_q;
                t_q     <= head_q;
                st_q    <= S_EXIT_UNLINK;
              end
            end
          endcase
        end
        S_WAKE: begin
          // due scan, first best priority wins
          if ((!have_q || prio_q[t_q] > prio_q[cand_q]) &&
              mode_q[t_q] == MODE_SLEEPING && c_q.now >= wake_q[t_q]) begin
            cand_q <= t_q;
            have_q <= 1'b1;
          end
          guard_q <= guard_q + 1'b1;
          t_q     <= tn;
          if (tn == stop_q || guard_q == 5'(TaskSlots)) begin
            st_q <= S_TICK_PICK0;
          end
        end
        S_TICK_PICK0: begin
          // a due sleeper found by the scan wins over the pending task and is taken
          logic [SlotW-1:0] p;
          logic             pv;
          p  = have_q ? cand_q : pend_q;
          pv = have_q || (pendv_q && mode_q[pend_q] == MODE_READY);
          if (curv_q) begin
            if (mode_q[cur_q] == MODE_RUNNING) mode_q[cur_q] <= MODE_SLEEPING;
            wake_q[cur_q] <= c_q.wake;
            if (pv) begin
              pendv_q  <= 1'b0;
              cur_q    <= p;
              mode_q[p] <= MODE_RUNNING;
              finish(ST_DONE, c_q.now);
            end else begin
              t_q     <= nxt_q[cur_q];
              guard_q <= '0;
              st_q    <= S_TICK_SWITCH;
            end
          end else if (pv) begin
            pendv_q   <= 1'b0;
            cur_q     <= p;
            curv_q    <= 1'b1;
            mode_q[p] <= MODE_RUNNING;
            finish(ST_DONE, c_q.now);
          end else begin
            t_q     <= head_q;
            guard_q <= '0;
            st_q    <= S_TICK_SWITCH;
          end
        end
        S_TICK_SWITCH: begin
          // ring walk for first ready slot
          if (!curv_q) begin
            if (mode_q[t_q] == MODE_READY) begin
              pendv_q     <= 1'b0;
              cur_q       <= t_q;
              curv_q      <= 1'b1;
              mode_q[t_q] <= MODE_RUNNING;
              finish(ST_DONE, c_q.now);
            end else if (tn == head_q || guard_q == 5'(TaskSlots)) begin
              finish(ST_REJECT, c_q.now);
            end else begin
              t_q     <= tn;
              guard_q <= guard_q + 1'b1;
            end
          end else if (mode_q[t_q] == MODE_READY || t_q == cur_q ||
                       guard_q == 5'(TaskSlots)) begin
            pendv_q     <= 1'b0;
            cur_q       <= t_q;
            mode_q[t_q] <= MODE_RUNNING;
            finish(ST_DONE, c_q.now);
          end else begin
            t_q     <= tn;
            guard_q <= guard_q + 1'b1;
          end
        end
        S_SLEEP: begin
          guard_q <= guard_q + 1'b1;
          if (mode_q[t_q] == MODE_READY) begin
            cur_q       <= t_q;
            mode_q[t_q] <= MODE_RUNNING;
            finish(ST_DONE, c_q.now);
          end else begin
            logic             h;
            logic [SlotW-1:0] cd, e;
            h  = have_q;
            cd = cand_q;
            e  = early_q;
            if (mode_q[t_q] == MODE_SLEEPING && c_q.now >= wake_q[t_q] &&
                (!have_q || prio_q[t_q] > prio_q[cand_q])) begin
              cd = t_q;
              h  = 1'b1;
            end
            if (mode_q[t_q] == MODE_SLEEPING && wake_q[t_q] < wake_q[early_q])
              e = t_q;
            cand_q  <= cd;
            have_q  <= h;
            early_q <= e;
            if (t_q == cur_q || guard_q == 5'(TaskSlots)) begin
              cur_q <= h ? cd : e;
              mode_q[h ? cd : e] <= MODE_RUNNING;
              finish(ST_DONE, h ? c_q.now : wake_q[e]);
            end else begin
              t_q <= tn;
            end
          end
        end
        S_EXIT_UNLINK: begin
          if (nxt_q[cur_q] == cur_q) begin
            ne_q    <= 1'b0;
            guard_q <= '0;
            st_q    <= S_EXIT_SCAN;
          end else if (nxt_q[prev_q] == cur_q || guard_q == 5'(TaskSlots)) begin
            nxt_q[prev_q] <= nxt_q[cur_q];
            if (head_q == cur_q) head_q <= prev_q;
            guard_q <= '0;
            st_q    <= S_EXIT_SCAN;
          end else begin
            prev_q  <= nxt_q[prev_q];
            guard_q <= guard_q + 1'b1;
          end
          mode_q[cur_q] <= MODE_FREE;
          curv_q        <= 1'b0;
          t_q           <= first_q;
        end
        S_EXIT_SCAN: begin
          if (pendv_q && pend_q != cur_q && mode_q[pend_q] == MODE_READY) begin
            pendv_q        <= 1'b0;
            cur_q          <= pend_q;
            curv_q         <= 1'b1;
            mode_q[pend_q] <= MODE_RUNNING;
            finish(ST_DONE, c_q.now);
          end else if (!ne_q) begin
            pendv_q <= 1'b0;
            finish(ST_NONE, c_q.now);
          end else begin
            logic             a;
            logic [SlotW-1:0] cd;
            logic [63:0]      b;
            a  = any_q;
            cd = cand_q;
            b  = best_q;
            if (mode_q[t_q] == MODE_SLEEPING) begin
              if (!any_q || w_eff < best_q) begin
                b  = w_eff;
                cd = t_q;
                a  = 1'b1;
              end else if (w_eff == best_q && prio_q[t_q] > prio_q[cand_q]) begin
                cd = t_q;
              end
            end
            any_q  <= a;
            cand_q <= cd;
            best_q <= b;
            t_q    <= tn;
            guard_q <= guard_q + 1'b1;
            if (tn == first_q || guard_q >= 5'(TaskSlots)) begin
              pendv_q <= 1'b0;
              if (a) begin
                cur_q      <= cd;
                curv_q     <= 1'b1;
                mode_q[cd] <= MODE_RUNNING;
                finish(ST_DONE, b);
              end else begin
                finish(ST_NONE, c_q.now);
              end
            end
          end
        end
        S_OUT: begin
          if (out_ready_i) st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/priority_wakeup_task_scheduler.sv
// Top level of the priority wake-up task scheduler.
// Depends on pwts_pkg, pwts_front, pwts_queue, pwts_back.
//
// Usage:
//   Input channel in_valid_i/in_ready_o carries one item per transfer
//   (kind, slot, prio, now_ticks, sleep_ms). Output channel
//   out_valid_o/out_ready_i returns exactly one result per item.
//   ticks_per_ms is written with cfg_we_i/cfg_wdata_i while idle.
// Flow:
//   The front end works on one item at a time: multiply, saturating add,
//   handoff to the queue, then ready again. The back end walks the ring
//   one slot per cycle and takes a new item only once the result of the
//   last one has been taken. The ring walk in the back end sets the rate;
//   a two-entry queue lets the front end take the next item while the
//   back end works.
// Reset: all slots free, ring empty, no current or pending task,
//   ticks_per_ms = 10000.
// Stall: a result holds on the outputs until out_ready_i; the queue then
//   fills and in_ready_o drops.
module priority_wakeup_task_scheduler import pwts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [3:0]  slot_i,
  input  logic [2:0]  prio_i,
  input  logic [63:0] now_ticks_i,
  input  logic [31:0] sleep_ms_i,
  input  logic        cfg_we_i,
  input  logic [19:0] cfg_wdata_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  run_slot_o,
  output logic        run_valid_o,
  output logic [63:0] start_ticks_o,
  output logic [1:0]  status_o
);

  logic [19:0] tpm_q;
  logic        f_valid, f_ready, b_valid, b_ready;
  cmd_t        f_cmd, b_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tpm_q <= TicksPerMsReset;
    else if (cfg_we_i) tpm_q <= cfg_wdata_i;
  end

  pwts_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i, .slot_i, .prio_i,
    .now_ticks_i, .sleep_ms_i, .ticks_per_ms_i(tpm_q),
    .cmd_valid_o(f_valid), .cmd_ready_i(f_ready), .cmd_o(f_cmd)
  );

  pwts_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(f_valid), .wr_ready_o(f_ready),
    .wr_data_i(f_cmd), .rd_valid_o(b_valid), .rd_ready_i(b_ready),
    .rd_data_o(b_cmd)
  );

  pwts_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(b_valid), .cmd_ready_o(b_ready),
    .cmd_i(b_cmd), .out_valid_o, .out_ready_i, .run_slot_o, .run_valid_o,
    .start_ticks_o, .status_o
  );

`ifndef SYNTH
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3) else $error("bad status");
  a_none_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_NONE) |-> !run_valid_o)
    else $error("status none with running task");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(start_ticks_o))
    else $error("result changed while stalled");
`endif

endmodule

>>> bench/tb_top.sv
// Self-checking bench for priority_wakeup_task_scheduler: directed table, then random items.
// A behavioral scheduler model predicts untyped results. Needs pwts_pkg and the RTL only.
module tb_top;
  import pwts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i = KIND_ADD;
  logic [3:0]  slot_i = '0;
  logic [2:0]  prio_i = '0;
  logic [63:0] now_ticks_i = '0;
  logic [31:0] sleep_ms_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [19:0] cfg_wdata_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  run_slot_o;
  logic        run_valid_o;
  logic [63:0] start_ticks_o;
  logic [1:0]  status_o;

  priority_wakeup_task_scheduler uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i, .slot_i, .prio_i,
    .now_ticks_i, .sleep_ms_i, .cfg_we_i, .cfg_wdata_i, .out_valid_o,
    .out_ready_i, .run_slot_o, .run_valid_o, .start_ticks_o, .status_o
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Types
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [3:0]  slot;
    logic        running;
    logic [63:0] start;
    status_e     st;
  } sched_res_t;

  typedef struct {
    kind_e       kind;
    logic [3:0]  slot;
    logic [2:0]  prio;
    logic [63:0] now;
    logic [31:0] ms;
    bit          typed;  // expected result typed in below
    sched_res_t  res;
  } stim_row_t;

  // ---------------------------------------------------------------------------
  // Scheduler model state (mirror of the block)
  // ---------------------------------------------------------------------------
  logic [3:0]  m_next [TaskSlots];
  mode_e       m_mode [TaskSlots];
  logic [2:0]  m_prio [TaskSlots];
  logic [63:0] m_wake [TaskSlots];
  logic [3:0]  m_head, m_cur, m_pend;
  logic        m_ring, m_curv, m_pendv;
  logic [19:0] m_tpm;

  sched_res_t  expected_q[$];
  int          errors = 0;
  bit          calm = 0;       // no idling on either side while set

  // now + ms * ticks_per_ms, saturating at all ones
  function automatic logic [63:0] wake_after(logic [63:0] now, logic [31:0] ms);
    logic [63:0] span, sum;
    span = 64'(ms) * 64'(m_tpm);
    sum  = now + span;
    return (sum < now) ? '1 : sum;
  endfunction

  // Mark the best due sleeper as pending ready.
  function automatic void mark_due(logic [63:0] now);
    logic [3:0] stop, t, cand;
    bit have;
    have = 0;
    cand = '0;
    if (!m_ring) return;
    if (m_pendv && m_mode[m_pend] == MODE_READY) return;
    stop = m_curv ? m_cur : m_head;
    t    = m_curv ? m_next[m_cur] : m_head;
    for (int g = 0; g <= TaskSlots; g++) begin
      if ((!have || m_prio[t] > m_prio[cand]) && m_mode[t] == MODE_SLEEPING &&
          now >= m_wake[t]) begin
        cand = t;
        have = 1;
      end
      t = m_next[t];
      if (t == stop) break;
    end
    if (!have) return;
    m_mode[cand] = MODE_READY;
    m_pend  = cand;
    m_pendv = 1'b1;
  endfunction

  function automatic status_e run_tick(logic [63:0] now);
    logic [3:0] n;
    bit found;
    if (!m_ring) return ST_REJECT;
    mark_due(now);
    if (!m_curv) begin
      found = 0;
      n = m_head;
      if (m_pendv && m_mode[m_pend] == MODE_READY) begin
        n = m_pend;
        found = 1;
      end else begin
        for (int g = 0; g <= TaskSlots; g++) begin
          if (m_mode[n] == MODE_READY) begin
            found = 1;
            break;
          end
          n = m_next[n];
          if (n == m_head) break;
        end
      end
      if (!found) return ST_REJECT;
      m_pendv = 1'b0;
      m_cur   = n;
      m_curv  = 1'b1;
      m_mode[n] = MODE_RUNNING;
      return ST_DONE;
    end
    if (m_mode[m_cur] == MODE_RUNNING) m_mode[m_cur] = MODE_SLEEPING;
    m_wake[m_cur] = wake_after(now, 32'd1);
    if (m_pendv && m_mode[m_pend] == MODE_READY) begin
      n = m_pend;
    end else begin
      n = m_cur;
      for (int g = 0; g <= TaskSlots; g++) begin
        n = m_next[n];
        if (m_mode[n] == MODE_READY || n == m_cur) break;
      end
    end
    m_pendv = 1'b0;
    m_cur   = n;
    m_mode[n] = MODE_RUNNING;
    return ST_DONE;
  endfunction

  function automatic status_e run_sleep(logic [63:0] now, logic [31:0] ms,
                                        inout logic [63:0] start);
    logic [3:0] self, n, cand, early;
    bit have, rdy;
    if (!m_curv) return ST_REJECT;
    self = m_cur;
    n = m_cur;
    cand = '0;
    have = 0;
    rdy = 0;
    m_mode[self] = MODE_SLEEPING;
    m_wake[self] = wake_after(now, ms);
    early = self;
    for (int g = 0; g <= TaskSlots; g++) begin
      n = m_next[n];
      if (m_mode[n] == MODE_READY) begin
        rdy = 1;
        break;
      end
      if (m_mode[n] == MODE_SLEEPING && now >= m_wake[n] &&
          (!have || m_prio[n] > m_prio[cand])) begin
        cand = n;
        have = 1;
      end
      if (m_mode[n] == MODE_SLEEPING && m_wake[n] < m_wake[early]) early = n;
      if (n == self) break;
    end
    if (rdy) m_cur = n;
    else if (have) m_cur = cand;
    else begin
      m_cur = early;
      start = m_wake[early];
    end
    m_mode[m_cur] = MODE_RUNNING;
    return ST_DONE;
  endfunction

  function automatic status_e run_exit(logic [63:0] now, inout logic [63:0] start);
    logic [3:0] self, first, t, cand, prev;
    logic [63:0] best, w;
    bit have, any;
    if (!m_curv) return ST_REJECT;
    self = m_cur;
    first = m_next[self];
    cand = '0;
    have = 0;
    best = '0;
    // unlink the exiting task
    if (m_ring) begin
      if (m_next[self] == self) m_ring = 1'b0;
      else begin
        prev = m_head;
        for (int g = 0; g <= TaskSlots && m_next[prev] != self; g++) prev = m_next[prev];
        m_next[prev] = m_next[self];
        if (m_head == self) m_head = prev;
      end
    end
    m_mode[self] = MODE_FREE;
    m_curv = 1'b0;
    if (m_pendv && m_pend != self && m_mode[m_pend] == MODE_READY) begin
      cand = m_pend;
      have = 1;
    end else if (m_ring) begin
      // earliest start among sleepers, best priority on a tie
      any = 0;
      t = first;
      for (int g = 0; g <= TaskSlots; g++) begin
        if (m_mode[t] == MODE_SLEEPING) begin
          w = (m_wake[t] > now) ? m_wake[t] : now;
          if (!any || w < best) begin
            best = w;
            cand = t;
            any = 1;
          end else if (w == best && m_prio[t] > m_prio[cand]) cand = t;
        end
        t = m_next[t];
        if (t == first) break;
      end
      have = any;
      if (any) start = best;
    end
    m_pendv = 1'b0;
    if (!have) return ST_NONE;
    m_cur  = cand;
    m_curv = 1'b1;
    m_mode[cand] = MODE_RUNNING;
    return ST_DONE;
  endfunction

  function automatic sched_res_t schedule(kind_e kind, logic [3:0] slot, logic [2:0] prio,
                                          logic [63:0] now, logic [31:0] ms);
    sched_res_t r;
    logic [63:0] start;
    status_e st;
    start = now;
    case (kind)
      KIND_ADD: begin
        if (m_mode[slot] != MODE_FREE) st = ST_REJECT;
        else begin
          if (!m_ring) begin
            m_next[slot] = slot;
            m_head = slot;
            m_ring = 1'b1;
          end else begin
            m_next[slot]   = m_next[m_head];
            m_next[m_head] = slot;
          end
          m_mode[slot] = MODE_SLEEPING;
          m_prio[slot] = prio;
          m_wake[slot] = '0;
          st = ST_DONE;
        end
      end
      KIND_TICK:  st = run_tick(now);
      KIND_SLEEP: st = run_sleep(now, ms, start);
      default:    st = run_exit(now, start);
    endcase
    r.slot = m_cur;
    r.running = m_curv;
    r.start = start;
    r.st = st;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  int stall_left = 0;

  // Result sink: random back-pressure plus field-by-field compare.
  always @(posedge clk_i) begin
    sched_res_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) report_mismatch("unexpected result", status_o, '0);
        else begin
          e = expected_q.pop_front();
          if (run_slot_o != e.slot)       report_mismatch("run_slot", run_slot_o, e.slot);
          if (run_valid_o != e.running)   report_mismatch("run_valid", run_valid_o, e.running);
          if (start_ticks_o != e.start)   report_mismatch("start_ticks", start_ticks_o, e.start);
          if (status_o != e.st)           report_mismatch("status", status_o, e.st);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!calm && $urandom_range(0, 99) < 15)
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // One transfer on the input channel; the prediction is queued on acceptance.
  task automatic send_item(kind_e kind, logic [3:0] slot, logic [2:0] prio,
                           logic [63:0] now, logic [31:0] ms, bit typed, sched_res_t typed_res);
    sched_res_t r;
    int gap;
    kind_i      <= kind;
    slot_i      <= slot;
    prio_i      <= prio;
    now_ticks_i <= now;
    sleep_ms_i  <= ms;
    in_valid_i  <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    r = schedule(kind, slot, prio, now, ms);
    expected_q.push_back(typed ? typed_res : r);
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Register write only once every result is back.
  task automatic write_tpm(logic [19:0] value);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    m_tpm = value;
  endtask

  stim_row_t   dir_rows[$];
  sched_res_t  none_res = '{slot: '0, running: 1'b0, start: '0, st: ST_DONE};

  initial begin
    logic [63:0] t_now;
    logic [63:0] now_v;
    logic [31:0] ms_v;
    kind_e       k;
    int          r;
    logic [19:0] tpm_set [4];

    for (int i = 0; i < TaskSlots; i++) begin
      m_mode[i] = MODE_FREE;
      m_next[i] = '0;
      m_prio[i] = '0;
      m_wake[i] = '0;
    end
    m_head = '0; m_cur = '0; m_pend = '0;
    m_ring = 1'b0; m_curv = 1'b0; m_pendv = 1'b0;
    m_tpm = TicksPerMsReset;

    // Directed table. Empty-scheduler rejects and the first adds are typed in; rest predicted.
    dir_rows = '{
      '{KIND_TICK,  4'd0,  3'd0, 64'd5,   32'd0, 1, '{4'd0, 1'b0, 64'd5, ST_REJECT}},
      '{KIND_SLEEP, 4'd0,  3'd0, 64'd6,   32'd3, 1, '{4'd0, 1'b0, 64'd6, ST_REJECT}},
      '{KIND_EXIT,  4'd0,  3'd0, 64'd7,   32'd0, 1, '{4'd0, 1'b0, 64'd7, ST_REJECT}},
      '{KIND_ADD,   4'd0,  3'd0, 64'd0,   32'd0, 1, '{4'd0, 1'b0, 64'd0, ST_DONE}},
      '{KIND_ADD,   4'd0,  3'd5, 64'd1,   32'd0, 1, '{4'd0, 1'b0, 64'd1, ST_REJECT}},
      '{KIND_ADD,   4'd15, 3'd7, 64'd2,   32'd0, 1, '{4'd0, 1'b0, 64'd2, ST_DONE}},
      '{KIND_ADD,   4'd9,  3'd7, 64'd3,   32'd0, 1, '{4'd0, 1'b0, 64'd3, ST_DONE}},
      '{KIND_ADD,   4'd5,  3'd3, 64'd4,   32'd0, 1, '{4'd0, 1'b0, 64'd4, ST_DONE}},
      '{KIND_TICK,  4'd0,  3'd0, 64'd100, 32'd0, 0, none_res},
      '{KIND_TICK,  4'd0,  3'd0, 64'd200, 32'd0, 0, none_res},
      '{KIND_SLEEP, 4'd0,  3'd0, 64'd300, '1,    0, none_res},
      '{KIND_SLEEP, 4'd0,  3'd0, 64'd301, 32'd0, 0, none_res},
      '{KIND_TICK,  4'd0,  3'd0, '1,      32'd0, 0, none_res},
      '{KIND_EXIT,  4'd0,  3'd0, 64'd1000, 32'd0, 0, none_res},
      '{KIND_EXIT,  4'd0,  3'd0, 64'd1001, 32'd0, 0, none_res},
      '{KIND_EXIT,  4'd0,  3'd0, 64'd1002, 32'd0, 0, none_res},
      '{KIND_EXIT,  4'd0,  3'd0, 64'd1003, 32'd0, 0, none_res},
      '{KIND_EXIT,  4'd0,  3'd0, 64'd1004, 32'd0, 0, none_res},
      '{KIND_ADD,   4'd3,  3'd1, 64'd5,   32'd0, 0, none_res},
      '{KIND_ADD,   4'd12, 3'd1, 64'd5,   32'd0, 0, none_res},
      '{KIND_TICK,  4'd0,  3'd0, 64'd10,  32'd0, 0, none_res},
      '{KIND_SLEEP, 4'd0,  3'd0, 64'd10,  32'd5, 0, none_res},
      '{KIND_SLEEP, 4'd0,  3'd0, 64'd11,  32'd9, 0, none_res}
    };

    // reset held from the start, then released
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_tpm(20'd1000000);
    calm = 1;
    foreach (dir_rows[i])
      send_item(dir_rows[i].kind, dir_rows[i].slot, dir_rows[i].prio, dir_rows[i].now,
                dir_rows[i].ms, dir_rows[i].typed, dir_rows[i].res);
    calm = 0;

    // Random phases, each under its own ticks_per_ms.
    tpm_set[0] = 20'd1;
    tpm_set[1] = 20'($urandom_range(2, 999999));
    tpm_set[2] = TicksPerMsReset;
    tpm_set[3] = 20'd1000000;
    t_now = 64'd20;
    for (int ph = 0; ph < 4; ph++) begin
      write_tpm(tpm_set[ph]);
      for (int n = 0; n < 185; n++) begin
        // some stretches with no idling at all
        if (n % 60 == 0) calm = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        if (r < 28) k = KIND_ADD;
        else if (r < 63) k = KIND_TICK;
        else if (r < 85) k = KIND_SLEEP;
        else k = KIND_EXIT;
        // timer mostly creeps forward; rare jumps cover every bit
        r = $urandom_range(0, 99);
        if (r < 3) t_now = {$urandom, $urandom};
        else if (r < 5) t_now = '1 - 64'($urandom_range(0, 3000));
        else t_now = t_now + 64'($urandom_range(0, 2 * m_tpm));
        now_v = t_now;
        r = $urandom_range(0, 99);
        if (r < 85) ms_v = $urandom_range(0, 3);
        else if (r < 95) ms_v = $urandom_range(0, 1000);
        else ms_v = $urandom;
        send_item(k, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)), now_v, ms_v,
                  0, none_res);
      end
    end
    calm = 0;
    in_valid_i <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule
